>>> rtl/tbs_pkg.sv
// ============================================================================
// TLV bucket scanner package
// Request types, status codes, register indexes and sizing constants shared
// by the scanner modules.
// ============================================================================
package tbs_pkg;

  // Default width of the message offset counters.
  localparam int unsigned OFFSET_BITS_DEF = 16;

  // Fixed field widths.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WANTED_TYPE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR_TYPE = 1'd1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd2;

  // Input request: one message byte.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_req_t;

  // Result request: one search outcome per message.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OUT_W-1:0]    payload_offset;
    logic [OUT_W-1:0]    payload_length;
  } out_req_t;

endpackage

>>> rtl/tlv_bucket_scanner_core.sv
// ============================================================================
// TLV bucket scanner core
// Streams a message byte by byte and reports the first bucket of a wanted
// type in its type-length-value list.
// ============================================================================
//
//   Channel  Direction  Ports                          Moves
//   in       input      in_valid, in_stall, in_data    one message byte
//   out      output     out_valid, out_stall, out_data one result per message
//   cfg      input      cfg_we, cfg_index, cfg_wdata   register write
//
// One byte per cycle unless a final byte waits: the parser finishes other
// bytes in the cycle after the edge that accepts them. A final byte loads its
// result into the output register once it has room, setting out_valid.
// Synchronous active-low reset empties both registers, restarts the parser
// and zeroes the type registers. Only a final byte waits on a full, stalled
// output register, and while it waits the input channel stalls.
//
// A message is a NUL-terminated name, a four-byte step word, then buckets of
// a big-endian 32-bit type, a big-endian 32-bit length and the payload. The
// terminator type ends the list. A message longer than 2^OFFSET_BITS - 1
// bytes reports too long.
module tlv_bucket_scanner_core
  import tbs_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_req_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  logic [WORD_W-1:0] wanted_r, term_r;
  logic              held_vld;
  in_req_t           held_data;
  logic              room;
  logic              step;
  out_req_t          result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r <= '0;
      term_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WANTED_TYPE:     wanted_r <= cfg_wdata;
        CFG_TERMINATOR_TYPE: term_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // A held byte is parsed unless it is a final byte and the output register
  // cannot take its result.
  assign step = held_vld & (~held_data.last_byte | room);

  tbs_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .take      (step),
    .held_vld  (held_vld),
    .held_data (held_data)
  );

  tbs_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .req             (held_data),
    .wanted_type     (wanted_r),
    .terminator_type (term_r),
    .result          (result)
  );

  tbs_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step & held_data.last_byte),
    .push_data (result),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/tbs_in_stage.sv
// ============================================================================
// TLV bucket scanner input register
// Holds one accepted byte until the parser consumes it.
// ============================================================================
module tbs_in_stage
  import tbs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  in_req_t in_data,
  input  logic    take,       // parser consumes the held byte this cycle
  output logic    held_vld,
  output in_req_t held_data
);

  logic    vld_r, vld_nxt;
  in_req_t data_r;

  // The register may load whenever it is empty or being drained.
  assign in_stall = vld_r & ~take;
  assign vld_nxt  = in_stall ? vld_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data_r <= in_data;
    end
  end

  assign held_vld  = vld_r;
  assign held_data = data_r;

endmodule

>>> rtl/tbs_parser.sv
// ============================================================================
// TLV bucket scanner parser
// Per-byte phase machine that walks the name, step word and bucket headers
// and forms the search result on the final byte of a message.
// ============================================================================
module tbs_parser
  import tbs_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  in_req_t           req,
  input  logic [WORD_W-1:0] wanted_type,
  input  logic [WORD_W-1:0] terminator_type,
  output out_req_t          result
);

  typedef enum logic [4:0] {
    PH_NAME = 5'b00001,
    PH_STEP = 5'b00010,
    PH_HDR  = 5'b00100,
    PH_PAY  = 5'b01000,
    PH_DONE = 5'b10000
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [OFFSET_BITS:0]   pos_r, pos_nxt;
  logic [2:0]             hcnt_r, hcnt_nxt;
  logic [WORD_W-1:0]      hshift_r, hshift_nxt;
  logic [WORD_W-1:0]      ctype_r, ctype_nxt;
  logic [WORD_W-1:0]      remain_r, remain_nxt;
  logic                   found_r, found_nxt;
  logic [OFFSET_BITS-1:0] foff_r, foff_nxt;
  logic [OUT_W-1:0]       flen_r, flen_nxt;
  logic [WORD_W-1:0]      shifted;

  assign shifted = {hshift_r[WORD_W-BYTE_W-1:0], req.data_byte};

  always_comb begin
    phase_nxt  = phase_r;
    hcnt_nxt   = hcnt_r;
    hshift_nxt = hshift_r;
    ctype_nxt  = ctype_r;
    remain_nxt = remain_r;
    found_nxt  = found_r;
    foff_nxt   = foff_r;
    flen_nxt   = flen_r;
    // The position counter saturates one past the longest legal message.
    pos_nxt    = pos_r[OFFSET_BITS] ? pos_r : pos_r + 1'b1;

    case (phase_r)
      PH_NAME: begin
        if (req.data_byte == '0) begin
          phase_nxt = PH_STEP;
          hcnt_nxt  = '0;
        end
      end
      PH_STEP: begin
        hcnt_nxt = hcnt_r + 1'b1;
        if (hcnt_r == 3'd3) begin
          hcnt_nxt   = '0;
          hshift_nxt = '0;
          phase_nxt  = PH_HDR;
        end
      end
      PH_HDR: begin
        hshift_nxt = shifted;
        hcnt_nxt   = hcnt_r + 1'b1;
        if (hcnt_r == 3'd3) begin
          ctype_nxt = shifted;
        end else if (hcnt_r == 3'd7) begin
          hcnt_nxt = '0;
          if (ctype_r == terminator_type) begin
            // The terminator ends the search even if its type is wanted.
            phase_nxt = PH_DONE;
          end else begin
            if (ctype_r == wanted_type) begin
              found_nxt = 1'b1;
              foff_nxt  = pos_r[OFFSET_BITS-1:0] + OFFSET_BITS'(1);
              flen_nxt  = shifted[OUT_W-1:0];
            end
            if (shifted == '0) begin
              if (found_nxt) begin
                phase_nxt = PH_DONE;
              end
            end else begin
              remain_nxt = shifted;
              phase_nxt  = PH_PAY;
            end
            hshift_nxt = '0;
          end
        end
      end
      PH_PAY: begin
        remain_nxt = remain_r - 1'b1;
        if (remain_r == WORD_W'(1)) begin
          phase_nxt = found_r ? PH_DONE : PH_HDR;
        end
      end
      default: begin
      end
    endcase
  end

  // The result is formed from the state after this byte.
  always_comb begin
    result = '{status: ST_NOT_FOUND, payload_offset: '0, payload_length: '0};
    if (pos_nxt[OFFSET_BITS]) begin
      result.status = ST_TOO_LONG;
    end else if (phase_nxt == PH_DONE && found_nxt) begin
      result.status         = ST_FOUND;
      result.payload_offset = OUT_W'(foff_nxt);
      result.payload_length = flen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_NAME;
      pos_r    <= '0;
      hcnt_r   <= '0;
      hshift_r <= '0;
      ctype_r  <= '0;
      remain_r <= '0;
      found_r  <= 1'b0;
      foff_r   <= '0;
      flen_r   <= '0;
    end else if (step) begin
      if (req.last_byte) begin
        // Each message starts from a clean state.
        phase_r  <= PH_NAME;
        pos_r    <= '0;
        hcnt_r   <= '0;
        hshift_r <= '0;
        ctype_r  <= '0;
        remain_r <= '0;
        found_r  <= 1'b0;
        foff_r   <= '0;
        flen_r   <= '0;
      end else begin
        phase_r  <= phase_nxt;
        pos_r    <= pos_nxt;
        hcnt_r   <= hcnt_nxt;
        hshift_r <= hshift_nxt;
        ctype_r  <= ctype_nxt;
        remain_r <= remain_nxt;
        found_r  <= found_nxt;
        foff_r   <= foff_nxt;
        flen_r   <= flen_nxt;
      end
    end
  end

endmodule

>>> rtl/tbs_out_stage.sv
// ============================================================================
// TLV bucket scanner output register
// Holds one result until the downstream side takes it.
// ============================================================================
module tbs_out_stage
  import tbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  out_req_t push_data,
  output logic     room,       // a result can be loaded this cycle
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  logic     vld_r, vld_nxt;
  out_req_t data_r;

  assign room    = ~vld_r | ~out_stall;
  assign vld_nxt = room ? push : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && room) begin
      data_r <= push_data;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

>>> tb/sv/tlv_bucket_scanner_chk.sv
// ============================================================================
// TLV bucket scanner checker
// Watches the byte, result and register ports of the scanner core, keeps its
// own copy of the parser state, predicts one result per message and compares
// every accepted result against the oldest prediction.
// ============================================================================
module tlv_bucket_scanner_chk
  import tbs_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_req_t              in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_req_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata,
  output int unsigned          mismatch_count,
  output int unsigned          results_owed
);

  typedef enum logic [2:0] {
    SCAN_NAME,
    SCAN_STEP,
    SCAN_HEADER,
    SCAN_PAYLOAD,
    SCAN_DONE
  } scan_phase_e;

  localparam int unsigned STEP_BYTES = 4;
  localparam int unsigned TYPE_BYTES = 4;
  localparam int unsigned HDR_BYTES  = 8;
  localparam logic [OFFSET_BITS:0] MAX_LEN = {1'b0, {OFFSET_BITS{1'b1}}};

  logic [WORD_W-1:0]    wanted_type;
  logic [WORD_W-1:0]    terminator_type;

  scan_phase_e          phase;
  logic [OFFSET_BITS:0] msg_pos;
  logic [3:0]           hdr_count;
  logic [WORD_W-1:0]    hdr_shift;
  logic [WORD_W-1:0]    bucket_type;
  logic [WORD_W-1:0]    payload_left;
  logic                 match_seen;
  logic [OUT_W-1:0]     match_offset;
  logic [OUT_W-1:0]     match_length;

  out_req_t             owed_q[$];
  int unsigned          errs = 0;
  int unsigned          owed_now = 0;

  assign mismatch_count = errs;
  assign results_owed   = owed_now;

  task automatic clear_scan();
    phase        = SCAN_NAME;
    msg_pos      = '0;
    hdr_count    = '0;
    hdr_shift    = '0;
    bucket_type  = '0;
    payload_left = '0;
    match_seen   = 1'b0;
    match_offset = '0;
    match_length = '0;
  endtask

  // Advances the parser by one byte and queues the outcome on a final byte.
  task automatic scan_byte(input in_req_t req);
    logic [OFFSET_BITS:0] pos;
    out_req_t             res;
    pos = msg_pos;
    case (phase)
      SCAN_NAME: begin
        if (req.data_byte == 8'h00) begin
          phase     = SCAN_STEP;
          hdr_count = '0;
        end
      end
      SCAN_STEP: begin
        hdr_count++;
        if (hdr_count >= STEP_BYTES) begin
          hdr_count = '0;
          hdr_shift = '0;
          phase     = SCAN_HEADER;
        end
      end
      SCAN_HEADER: begin
        hdr_shift = {hdr_shift[WORD_W-9:0], req.data_byte};
        hdr_count++;
        if (hdr_count == TYPE_BYTES) begin
          bucket_type = hdr_shift;
        end else if (hdr_count >= HDR_BYTES) begin
          hdr_count = '0;
          if (bucket_type == terminator_type) begin
            phase = SCAN_DONE;
          end else begin
            if (bucket_type == wanted_type) begin
              match_seen   = 1'b1;
              match_offset = OUT_W'(pos + 1'b1);
              match_length = hdr_shift[OUT_W-1:0];
            end
            if (hdr_shift == '0) begin
              if (match_seen) phase = SCAN_DONE;
            end else begin
              payload_left = hdr_shift;
              phase        = SCAN_PAYLOAD;
            end
            hdr_shift = '0;
          end
        end
      end
      SCAN_PAYLOAD: begin
        payload_left--;
        if (payload_left == '0) phase = match_seen ? SCAN_DONE : SCAN_HEADER;
      end
      default: ;
    endcase
    if (msg_pos <= MAX_LEN) msg_pos++;

    if (req.last_byte) begin
      if (msg_pos > MAX_LEN) begin
        res = '{status: ST_TOO_LONG, payload_offset: '0, payload_length: '0};
      end else if (phase == SCAN_DONE && match_seen) begin
        res = '{status: ST_FOUND, payload_offset: match_offset,
                payload_length: match_length};
      end else begin
        res = '{status: ST_NOT_FOUND, payload_offset: '0, payload_length: '0};
      end
      owed_q.push_back(res);
      clear_scan();
    end
  endtask

  task automatic check_result(input out_req_t got);
    out_req_t exp;
    if (owed_q.size() == 0) begin
      $display("%0t: unexpected result status %0d offset %0d length %0d",
               $time, got.status, got.payload_offset, got.payload_length);
      errs++;
    end else begin
      exp = owed_q.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, exp.status, got.status);
        errs++;
      end
      if (got.payload_offset !== exp.payload_offset) begin
        $display("%0t: payload_offset mismatch, expected %0d actual %0d",
                 $time, exp.payload_offset, got.payload_offset);
        errs++;
      end
      if (got.payload_length !== exp.payload_length) begin
        $display("%0t: payload_length mismatch, expected %0d actual %0d",
                 $time, exp.payload_length, got.payload_length);
        errs++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      wanted_type     = '0;
      terminator_type = '0;
      clear_scan();
      owed_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WANTED_TYPE:     wanted_type     = cfg_wdata;
          CFG_TERMINATOR_TYPE: terminator_type = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) scan_byte(in_data);
      if (out_valid && !out_stall) check_result(out_data);
    end
    owed_now <= owed_q.size();
  end

endmodule

>>> tb/sv/tlv_bucket_scanner_core_tb.sv
// ============================================================================
// TLV bucket scanner core testbench
// Streams directed and random messages through the scanner under changing
// handshake pressure and type settings; a separate checker predicts and
// compares every search result, and this module reports the verdict.
// ============================================================================
module tlv_bucket_scanner_core_tb;
  import tbs_pkg::*;

  // Longest message that still reports a real outcome.
  localparam int unsigned MAX_MSG = (1 << OFFSET_BITS_DEF) - 1;
  // Name terminator, step word and one bucket header ahead of the payload.
  localparam int unsigned LEAD_BYTES = 13;
  // Random budget for each of the three handshake phases.
  localparam int unsigned PHASE_BYTES = 620;
  localparam int unsigned PHASE_MSGS  = 18;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_req_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_req_t             out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_wdata = '0;

  int unsigned          mismatch_count;
  int unsigned          results_owed;

  // Percent chance per cycle that the sender holds back or the receiver
  // stalls.
  int unsigned          send_idle = 0;
  int unsigned          recv_idle = 0;

  // Message under construction, and the type settings the generator aims at.
  logic [7:0]           msg_bytes[$];
  logic [WORD_W-1:0]    wanted_cfg = '0;
  logic [WORD_W-1:0]    term_cfg   = '0;
  int unsigned          sent_bytes = 0;
  int unsigned          sent_msgs  = 0;

  tlv_bucket_scanner_core DUT (.*);

  tlv_bucket_scanner_chk u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side stalls at random; with recv_idle at zero it never does.
  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < recv_idle);

  // Appends a 32-bit word, most significant byte first, as the headers are.
  function automatic void add_word(input logic [WORD_W-1:0] w);
    for (int i = 3; i >= 0; i--) msg_bytes.push_back(w[8*i +: 8]);
  endfunction

  // A short name of nonzero bytes, possibly empty, its NUL, and an arbitrary step word.
  function automatic void add_preamble();
    int unsigned name_chars;
    name_chars = $urandom_range(0, 5);
    repeat (name_chars) msg_bytes.push_back(8'($urandom_range(1, 255)));
    msg_bytes.push_back(8'h00);
    add_word($urandom);
  endfunction

  // One bucket header followed by body payload bytes. A body shorter than
  // the length field leaves the payload running past the message end.
  function automatic void add_bucket(input logic [WORD_W-1:0] btype,
                                     input logic [WORD_W-1:0] blen,
                                     input int unsigned body);
    add_word(btype);
    add_word(blen);
    repeat (body) msg_bytes.push_back(8'($urandom));
  endfunction

  // Bucket types lean toward the two configured codes so that matches and
  // early list ends are common, with the extreme codes thrown in.
  function automatic logic [WORD_W-1:0] pick_type();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return wanted_cfg;
      4, 5:       return term_cfg;
      6:          return '0;
      7:          return '1;
      default:    return $urandom;
    endcase
  endfunction

  // Mostly well-formed messages with random content; the rest are pure
  // noise or well-formed messages cut off at a random byte.
  function automatic void build_random_message();
    int unsigned n_buckets;
    int unsigned blen;
    int unsigned body;
    int unsigned cut;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 16)) msg_bytes.push_back(8'($urandom));
    end else begin
      add_preamble();
      n_buckets = $urandom_range(0, 4);
      for (int i = 0; i < n_buckets; i++) begin
        blen = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 9);
        body = (blen > 12) ? $urandom_range(0, 12) : blen;
        add_bucket(pick_type(), blen, body);
        if (body != blen) break;
      end
      case ($urandom_range(0, 3))
        0: begin
          add_bucket(term_cfg, 0, 0);
          add_bucket(wanted_cfg, 1, 1);
        end
        1: repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom));
        default: ;
      endcase
      if ($urandom_range(0, 6) == 0) begin
        cut = $urandom_range(1, msg_bytes.size());
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
    end
  endfunction

  // Offers one byte request and returns at the edge that accepts it. The
  // sender may hold valid low for a random number of cycles first; the
  // payload does not change while the request waits on a stall.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: fin};
    do @(posedge clk); while (in_stall);
  endtask

  // Sends the queued message with the final flag on its last byte. Valid
  // stays high into the next message unless the sender chooses to idle.
  task automatic send_message();
    int unsigned n;
    n = msg_bytes.size();
    for (int unsigned i = 0; i < n; i++) send_byte(msg_bytes[i], i == n - 1);
    sent_bytes += n;
    sent_msgs++;
    msg_bytes.delete();
  endtask

  // Stops sending and waits for every outstanding result, then waits out the
  // path from the final byte through the input and output registers to the result.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [WORD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Registers only change while the scanner is idle.
  task automatic set_types(input logic [WORD_W-1:0] w,
                           input logic [WORD_W-1:0] t);
    settle();
    write_reg(CFG_WANTED_TYPE, w);
    write_reg(CFG_TERMINATOR_TYPE, t);
    wanted_cfg = w;
    term_cfg   = t;
  endtask

  // Picks a new type setting: fully random, the opposite extremes, or the
  // two codes equal, in which case a match can never be reported.
  task automatic reconfigure();
    logic [WORD_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 5))
      0:       set_types('0, '1);
      1:       set_types('1, '0);
      2:       set_types(w, w);
      3:       set_types('1, '1);
      default: set_types(w, $urandom);
    endcase
  endtask

  // Stimulus: a directed set of messages, then three random phases with
  // different handshake pressure, then the two length boundary messages.
  initial begin
    int unsigned base_bytes;
    int unsigned base_msgs;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 33;
    recv_idle = 61;

    // Both type registers are zero out of reset. A lone nonzero byte never
    // finishes the name.
    msg_bytes.push_back(8'hFF);
    send_message();
    // An empty name with nothing after it: the step word is cut short.
    msg_bytes.push_back(8'h00);
    send_message();
    // A bucket header cut off after three of its eight bytes.
    msg_bytes.push_back(8'h00);
    add_word(32'hFFFF_FFFF);
    repeat (3) msg_bytes.push_back(8'h00);
    send_message();
    // With both codes at zero a type-zero bucket ends the list unmatched.
    add_preamble();
    add_bucket('0, 2, 2);
    send_message();

    set_types('1, '0);
    // A match behind a bucket that is skipped, ending on its last payload
    // byte.
    add_preamble();
    add_bucket(32'h0000_0005, 1, 1);
    add_bucket('1, 3, 3);
    send_message();
    // A zero-length match is complete at its header; later bytes are
    // ignored.
    add_preamble();
    add_bucket('1, 0, 0);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'hFF);
    send_message();
    // The terminator comes first, so the later match is never seen.
    add_preamble();
    add_bucket('0, 4, 4);
    add_bucket('1, 1, 1);
    send_message();
    // A matching payload that runs past the final byte.
    add_preamble();
    add_bucket('1, 5, 2);
    send_message();
    // A non-matching payload with the largest length runs past the end.
    add_preamble();
    add_bucket(32'h0000_0007, '1, 3);
    send_message();
    // An empty non-matching bucket followed by the match.
    add_preamble();
    add_bucket(32'h8000_0000, 0, 0);
    add_bucket('1, 1, 1);
    send_message();

    // Equal codes: the terminator check wins over the match.
    set_types(32'h0000_0005, 32'h0000_0005);
    add_preamble();
    add_bucket(32'h0000_0005, 2, 2);
    send_message();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 33;
          recv_idle = 61;
        end
        1: begin
          send_idle = 61;
          recv_idle = 33;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      reconfigure();
      base_bytes = sent_bytes;
      base_msgs  = sent_msgs;
      while (sent_bytes - base_bytes < PHASE_BYTES ||
             sent_msgs - base_msgs < PHASE_MSGS) begin
        // Now and then drain the pipeline, either to change the types or
        // just to let the result side run dry.
        if ((sent_msgs - base_msgs) % 15 == 14) reconfigure();
        else if ($urandom_range(0, 9) == 0) settle();
        build_random_message();
        send_message();
      end
    end

    // Length boundaries, with the handshake running flat out. The longest
    // allowed message ends exactly on a matching payload.
    set_types($urandom, '0);
    if (wanted_cfg == term_cfg) set_types(32'h0000_0001, '0);
    msg_bytes.push_back(8'h00);
    add_word($urandom);
    add_bucket(wanted_cfg, MAX_MSG - LEAD_BYTES, MAX_MSG - LEAD_BYTES);
    send_message();
    // One byte more reports too long even though a match came early.
    msg_bytes.push_back(8'h00);
    add_word($urandom);
    add_bucket(wanted_cfg, 0, 0);
    repeat (MAX_MSG + 1 - LEAD_BYTES) msg_bytes.push_back(8'($urandom));
    send_message();

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hang anywhere in the run.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
